>>> hdl/dtt_pkg.sv
package dtt_pkg;

  // Table geometry
  localparam int DEPTH     = 32;
  localparam int TIME_BITS = 41;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W   = $clog2(DEPTH + 1);

  // Field widths
  localparam int TAG_W   = 16;
  localparam int DELAY_W = 32;
  localparam int NOW_W   = 40;
  localparam int OCC_W   = 6;

  // Operation codes
  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_ERASE  = 2'd1,
    FN_PRUNE  = 2'd2
  } func_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_APPEND  = 2'd0,
    KIND_ERASE   = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [TAG_W-1:0]   tag;
    logic [DELAY_W-1:0] ttl_ms;
    logic [NOW_W-1:0]   now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             ok;
    logic [TAG_W-1:0] expired_tag;
    logic             last;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  // One stored task
  typedef struct packed {
    logic [TAG_W-1:0]     tag;
    logic [TIME_BITS-1:0] deadline;
  } entry_t;

endpackage

>>> hdl/dtt_ram.sv
module dtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/deadline_task_table.sv
// Deadline task table: an ordered list of up to DEPTH pending tasks.
// Input channel (in_valid/in_ready/in_data) takes one command per transfer:
// append a tag with deadline now_ms + ttl_ms, erase the first entry with
// a tag, or prune every entry whose deadline is strictly before now_ms.
// Result channel (out_valid/out_ready/out_data) gives one status per append
// or erase; prune gives one result per expired entry (the final one marked
// with last) or a single "none" result. Opcode 3 is dropped silently.
// Erase and prune walk the table through one RAM read port, reading each held
// entry, then comparing and compacting it.
// One shared 41-bit adder forms append deadlines and prune compares.
// in_ready is high only while the sequencer is idle; a finished result may
// still sit in the output register while the next command is taken.
// A stalled receiver holds the output register; a prune scan waits on it to flush an expired entry.
// Reset empties the table at once; no clearing pass is needed.
module deadline_task_table
  import dtt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_APP  = 5'b00010,
    S_RD   = 5'b00100,
    S_EV   = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  in_item_t             item_r;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]   lim_r, lim_nxt;
  logic [COUNT_W-1:0]   rd_r, rd_nxt;
  logic [COUNT_W-1:0]   wr_r, wr_nxt;
  logic                 found_r, found_nxt;
  logic                 pend_r, pend_nxt;
  logic [TAG_W-1:0]     pend_tag_r, pend_tag_nxt;
  logic [COUNT_W-1:0]   pend_occ_r, pend_occ_nxt;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic                 emit;
  out_item_t            emit_data;
  logic                 out_free;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  entry_t               ram_wdata;
  entry_t               ram_rdata;

  logic [TIME_BITS-1:0] alu_a, alu_b;
  logic                 alu_sub;
  logic [TIME_BITS:0]   alu_sum;
  logic                 expired;
  logic                 tag_hit;
  logic                 is_prune;

  dtt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Shared adder: now + ttl for append, deadline - now for prune
  always_comb begin
    alu_sub = (state_r != S_APP);
    if (alu_sub) begin
      alu_a = ram_rdata.deadline;
      alu_b = TIME_BITS'(item_r.now_ms);
    end else begin
      alu_a = TIME_BITS'(item_r.now_ms);
      alu_b = TIME_BITS'(item_r.ttl_ms);
    end
    alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {TIME_BITS{alu_sub}}}
              + (TIME_BITS + 1)'(alu_sub);
  end

  // No carry out of the subtract means deadline < now
  assign expired  = !alu_sum[TIME_BITS];
  assign tag_hit  = !found_r && (ram_rdata.tag == item_r.tag);
  assign is_prune = (item_r.func == FN_PRUNE);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    lim_nxt      = lim_r;
    rd_nxt       = rd_r;
    wr_nxt       = wr_r;
    found_nxt    = found_r;
    pend_nxt     = pend_r;
    pend_tag_nxt = pend_tag_r;
    pend_occ_nxt = pend_occ_r;
    ram_we       = 1'b0;
    ram_waddr    = wr_r[ADDR_W-1:0];
    ram_wdata    = ram_rdata;
    emit         = 1'b0;
    emit_data    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rd_nxt    = '0;
          wr_nxt    = '0;
          found_nxt = 1'b0;
          pend_nxt  = 1'b0;
          lim_nxt   = cnt_r;
          unique case (in_data.func) inside
            FN_APPEND: state_nxt = S_APP;
            FN_ERASE, FN_PRUNE: state_nxt = (cnt_r == '0) ? S_FIN : S_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_APP: begin
        if (out_free) begin
          emit_data.kind = KIND_APPEND;
          emit_data.last = 1'b1;
          if (cnt_r < COUNT_W'(DEPTH)) begin
            ram_we         = 1'b1;
            ram_waddr      = cnt_r[ADDR_W-1:0];
            ram_wdata.tag      = item_r.tag;
            ram_wdata.deadline = alu_sum[TIME_BITS-1:0];
            cnt_nxt        = cnt_r + 1'b1;
            emit_data.ok   = 1'b1;
          end
          emit_data.occupancy = OCC_W'(cnt_nxt);
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_RD: begin
        state_nxt = S_EV;
      end

      S_EV: begin
        if (is_prune && expired) begin
          // Hold the newest expired entry; flush the older one first
          if (!pend_r || out_free) begin
            if (pend_r) begin
              emit                = 1'b1;
              emit_data.kind      = KIND_EXPIRED;
              emit_data.expired_tag = pend_tag_r;
              emit_data.occupancy = OCC_W'(pend_occ_r);
            end
            pend_nxt     = 1'b1;
            pend_tag_nxt = ram_rdata.tag;
            pend_occ_nxt = cnt_r - 1'b1;
            cnt_nxt      = cnt_r - 1'b1;
            rd_nxt       = rd_r + 1'b1;
            state_nxt    = (rd_nxt == lim_r) ? S_FIN : S_RD;
          end
        end else if (!is_prune && tag_hit) begin
          found_nxt = 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
          rd_nxt    = rd_r + 1'b1;
          state_nxt = (rd_nxt == lim_r) ? S_FIN : S_RD;
        end else begin
          // Kept entry moves down to the compaction pointer
          ram_we    = 1'b1;
          wr_nxt    = wr_r + 1'b1;
          rd_nxt    = rd_r + 1'b1;
          state_nxt = (rd_nxt == lim_r) ? S_FIN : S_RD;
        end
      end

      S_FIN: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_data.last = 1'b1;
          if (!is_prune) begin
            emit_data.kind      = KIND_ERASE;
            emit_data.ok        = found_r;
            emit_data.occupancy = OCC_W'(cnt_r);
          end else if (pend_r) begin
            emit_data.kind        = KIND_EXPIRED;
            emit_data.expired_tag = pend_tag_r;
            emit_data.occupancy   = OCC_W'(pend_occ_r);
          end else begin
            emit_data.kind      = KIND_NONE;
            emit_data.occupancy = OCC_W'(cnt_r);
          end
          pend_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      found_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Scan pointers and held command
  always_ff @(posedge clk) begin
    lim_r      <= lim_nxt;
    rd_r       <= rd_nxt;
    wr_r       <= wr_nxt;
    pend_tag_r <= pend_tag_nxt;
    pend_occ_r <= pend_occ_nxt;
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/dtt_checker.sv
module dtt_checker
  import dtt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Occupancy never exceeds the table depth
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.occupancy <= OCC_W'(DEPTH))
    else $error("occupancy beyond table depth");

  // Status and none results close their command
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_APPEND || out_data.kind == KIND_ERASE ||
                  out_data.kind == KIND_NONE) |-> out_data.last)
    else $error("status result without last");

  // Prune results never carry ok
  a_prune_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_EXPIRED || out_data.kind == KIND_NONE)
    |-> !out_data.ok)
    else $error("prune result with ok set");

  // Only expired results carry a tag
  a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_EXPIRED |-> out_data.expired_tag == '0)
    else $error("tag on non-expired result");

endmodule

bind deadline_task_table dtt_checker u_dtt_checker (.*);
